// File: sv/bpc_pkg.sv
// Package: shared types, constants and helpers for the pressure compensation block.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

  localparam int unsigned QW = 32;

  localparam logic [1:0] REG_OSS = 2'd0;
  localparam logic [1:0] REG_CAL1 = 2'd1;
  localparam logic [1:0] REG_CAL2 = 2'd2;
  localparam logic [1:0] REG_CAL3 = 2'd3;

  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] K_X1 = 32'd3038;
  localparam logic [31:0] K_X2 = 32'd7357;
  localparam logic [31:0] K_ADD = 32'd3791;
  localparam logic [31:0] K_SCALE = 32'd50000;
  localparam logic [31:0] SIGN_BIT = 32'h80000000;

  typedef struct packed {
    logic [15:0] temp_raw;
    logic [23:0] pres_raw;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] temp_deci;
    logic signed [31:0] pressure_pa;
    logic               div_fault;
  } out_req_t;

  typedef struct packed {
    logic [1:0]  oss;
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
  } calib_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    asr = 32'($signed(v) >>> s);
  endfunction

endpackage
`default_nettype wire

// File: sv/bpc_if.sv
// Interfaces: valid/ready channels for input and result requests.
`timescale 1ns / 1ps
`default_nettype none
interface bpc_in_if;
  logic valid;
  logic ready;
  bpc_pkg::in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpc_out_if;
  logic valid;
  logic ready;
  bpc_pkg::out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/barometric_pressure_compensation.sv
// Top level: pipelined barometer temperature and pressure compensation.
//
// Input channel in_ carries one request per cycle while in_ready is high: temp_raw and pres_raw.
// Result channel out_ returns temp_deci, pressure_pa and div_fault, in order.
// Calibration words and oversampling come through the cfg_ write port and
// must be written while no request is in flight.
// Throughput: one request per cycle unless out_ stalls. Each request passes through
// two 32-stage pipelined dividers (temperature, then pressure), the multiply
// stages between them and one output register.
// A zero divisor returns zeros and sets div_fault.
// Reset (synchronous, rst_n low) clears all valid bits and all
// configuration registers to zero.
// When the receiver holds out_ready low while a result waits, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module barometric_pressure_compensation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bpc_in_if.sink           in_ch,
  bpc_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [63:0] cfg_wdata
);

  logic [1:0]  oss_r;
  logic [63:0] cal1_r;
  logic [63:0] cal2_r;
  logic [31:0] cal3_r;
  bpc_pkg::calib_t cal;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oss_r  <= '0;
      cal1_r <= '0;
      cal2_r <= '0;
      cal3_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        bpc_pkg::REG_OSS:  oss_r  <= cfg_wdata[1:0];
        bpc_pkg::REG_CAL1: cal1_r <= cfg_wdata;
        bpc_pkg::REG_CAL2: cal2_r <= cfg_wdata;
        bpc_pkg::REG_CAL3: cal3_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.oss = oss_r;
    cal.ac1 = bpc_pkg::sx16(cal1_r[15:0]);
    cal.ac2 = bpc_pkg::sx16(cal1_r[31:16]);
    cal.ac3 = bpc_pkg::sx16(cal1_r[47:32]);
    cal.ac4 = {16'd0, cal1_r[63:48]};
    cal.ac5 = {16'd0, cal2_r[15:0]};
    cal.ac6 = {16'd0, cal2_r[31:16]};
    cal.b1  = bpc_pkg::sx16(cal2_r[47:32]);
    cal.b2  = bpc_pkg::sx16(cal2_r[63:48]);
    cal.mc  = bpc_pkg::sx16(cal3_r[15:0]);
    cal.md  = bpc_pkg::sx16(cal3_r[31:16]);
  end

  // Pipeline advance: whole pipe moves when the output slot is free or taken.
  logic out_vld_r;
  logic adv;
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic in_acc;
  assign in_acc = in_ch.valid && adv;

  // Stage 1: ut - ac6, shifted up.
  logic        s1_vld_r;
  logic [31:0] s1_dif_r;
  logic [31:0] s1_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (adv) s1_vld_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dif_r <= {16'd0, in_ch.data.temp_raw} - cal.ac6;
      s1_up_r  <= {8'd0, in_ch.data.pres_raw} >> (5'd8 - {3'd0, cal.oss});
    end
  end

  // Stage 2: x1a.
  logic        s2_vld_r;
  logic [31:0] s2_x1a_r;
  logic [31:0] s2_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (adv) s2_vld_r <= s1_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x1a_r <= bpc_pkg::asr(32'(s1_dif_r * cal.ac5), 5'd15);
      s2_up_r  <= s1_up_r;
    end
  end

  // Stage 3: divisor, magnitudes for the signed temperature division.
  logic        s3_vld_r;
  logic        s3_tz_r;
  logic        s3_neg_r;
  logic [31:0] s3_num_r;
  logic [31:0] s3_den_r;
  logic [31:0] s3_x1a_r;
  logic [31:0] s3_up_r;
  logic [31:0] den_w;
  logic [31:0] mcs_w;
  assign den_w = s2_x1a_r + cal.md;
  assign mcs_w = cal.mc << 11;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (adv) s3_vld_r <= s2_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tz_r  <= den_w == '0;
      s3_neg_r <= mcs_w[31] ^ den_w[31];
      s3_num_r <= mcs_w[31] ? -mcs_w : mcs_w;
      s3_den_r <= (den_w == '0) ? 32'd1 : (den_w[31] ? -den_w : den_w);
      s3_x1a_r <= s2_x1a_r;
      s3_up_r  <= s2_up_r;
    end
  end

  logic        d1_vld;
  logic [31:0] d1_quo;
  logic [95:0] d1_side;
  bpc_div u_div_t (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(s3_vld_r),
    .in_num(s3_num_r), .in_den(s3_den_r), .out_vld(d1_vld), .out_quo(d1_quo)
  );
  bpc_delay u_dly_t (
    .clk(clk), .adv(adv),
    .d({s3_x1a_r, s3_up_r, s3_tz_r, s3_neg_r, 30'd0}), .q(d1_side)
  );

  // Stage 4: b5, t, b6.
  logic        s4_vld_r;
  logic        s4_tz_r;
  logic [31:0] s4_t_r;
  logic [31:0] s4_b6_r;
  logic [31:0] s4_up_r;
  logic [31:0] b5_w;
  assign b5_w = d1_side[95:64] + (d1_side[30] ? -d1_quo : d1_quo);
  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (adv) s4_vld_r <= d1_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_tz_r <= d1_side[31];
      s4_t_r  <= bpc_pkg::asr(b5_w + 32'd8, 5'd4);
      s4_b6_r <= b5_w - bpc_pkg::B6_OFFSET;
      s4_up_r <= d1_side[63:32];
    end
  end

  // Stage 5: sq, ac2*b6, ac3*b6.
  logic        s5_vld_r;
  logic        s5_tz_r;
  logic [31:0] s5_t_r, s5_sq_r, s5_x2b_r, s5_x1c_r, s5_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else if (adv) s5_vld_r <= s4_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_tz_r  <= s4_tz_r;
      s5_t_r   <= s4_t_r;
      s5_sq_r  <= bpc_pkg::asr(32'(s4_b6_r * s4_b6_r), 5'd12);
      s5_x2b_r <= bpc_pkg::asr(32'(cal.ac2 * s4_b6_r), 5'd11);
      s5_x1c_r <= bpc_pkg::asr(32'(cal.ac3 * s4_b6_r), 5'd13);
      s5_up_r  <= s4_up_r;
    end
  end

  // Stage 6: b2*sq, b1*sq.
  logic        s6_vld_r;
  logic        s6_tz_r;
  logic [31:0] s6_t_r, s6_x3b_r, s6_x3c_r, s6_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else if (adv) s6_vld_r <= s5_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_tz_r  <= s5_tz_r;
      s6_t_r   <= s5_t_r;
      s6_x3b_r <= bpc_pkg::asr(32'(cal.b2 * s5_sq_r), 5'd11) + s5_x2b_r;
      s6_x3c_r <= bpc_pkg::asr(s5_x1c_r + bpc_pkg::asr(32'(cal.b1 * s5_sq_r), 5'd16)
                  + 32'd2, 5'd2);
      s6_up_r  <= s5_up_r;
    end
  end

  // Stage 7: b3, b4.
  logic        s7_vld_r;
  logic        s7_tz_r;
  logic [31:0] s7_t_r, s7_b3_r, s7_b4_r, s7_up_r;
  logic [31:0] b3_w;
  assign b3_w = ((cal.ac1 * 32'd4 + s6_x3b_r) << cal.oss) + 32'd2;
  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else if (adv) s7_vld_r <= s6_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_tz_r <= s6_tz_r;
      s7_t_r  <= s6_t_r;
      s7_b3_r <= bpc_pkg::asr(b3_w, 5'd2);
      s7_b4_r <= 32'(cal.ac4 * (s6_x3c_r + 32'd32768)) >> 15;
      s7_up_r <= s6_up_r;
    end
  end

  // Stage 8: b7.
  logic        s8_vld_r;
  logic        s8_tz_r;
  logic [31:0] s8_t_r, s8_b7_r, s8_b4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s8_vld_r <= 1'b0;
    else if (adv) s8_vld_r <= s7_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_tz_r <= s7_tz_r;
      s8_t_r  <= s7_t_r;
      s8_b7_r <= 32'((s7_up_r - s7_b3_r) * (bpc_pkg::K_SCALE >> cal.oss));
      s8_b4_r <= s7_b4_r;
    end
  end

  // Stage 9: set up unsigned pressure division.
  logic        s9_vld_r;
  logic [31:0] s9_num_r, s9_den_r;
  logic        s9_big_r, s9_flt_r;
  logic [31:0] s9_t_r;
  logic        big_w, flt_w;
  assign big_w = s8_b7_r >= bpc_pkg::SIGN_BIT;
  assign flt_w = s8_tz_r || (s8_b4_r == '0);
  always_ff @(posedge clk) begin
    if (!rst_n) s9_vld_r <= 1'b0;
    else if (adv) s9_vld_r <= s8_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s9_num_r <= big_w ? s8_b7_r : (s8_b7_r << 1);
      s9_den_r <= (s8_b4_r == '0) ? 32'd1 : s8_b4_r;
      s9_big_r <= big_w;
      s9_flt_r <= flt_w;
      s9_t_r   <= s8_t_r;
    end
  end

  logic        d2_vld;
  logic [31:0] d2_quo;
  logic [95:0] d2_side;
  bpc_div u_div_p (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(s9_vld_r),
    .in_num(s9_num_r), .in_den(s9_den_r), .out_vld(d2_vld), .out_quo(d2_quo)
  );
  bpc_delay u_dly_p (
    .clk(clk), .adv(adv),
    .d({s9_t_r, s9_big_r, s9_flt_r, 62'd0}), .q(d2_side)
  );

  // Stage 10: pa, hp*hp, 7357*pa.
  logic        s10_vld_r;
  logic        s10_flt_r;
  logic [31:0] s10_t_r, s10_pa_r, s10_x1d_r, s10_x2e_r;
  logic [31:0] pa_w, hp_w;
  assign pa_w = d2_side[63] ? (d2_quo << 1) : d2_quo;
  assign hp_w = bpc_pkg::asr(pa_w, 5'd8);
  always_ff @(posedge clk) begin
    if (!rst_n) s10_vld_r <= 1'b0;
    else if (adv) s10_vld_r <= d2_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s10_flt_r <= d2_side[62];
      s10_t_r   <= d2_side[95:64];
      s10_pa_r  <= pa_w;
      s10_x1d_r <= 32'(hp_w * hp_w);
      s10_x2e_r <= bpc_pkg::asr(32'(32'd0 - bpc_pkg::K_X2 * pa_w), 5'd16);
    end
  end

  // Stage 11: x1e.
  logic        s11_vld_r;
  logic        s11_flt_r;
  logic [31:0] s11_t_r, s11_pa_r, s11_x1e_r, s11_x2e_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s11_vld_r <= 1'b0;
    else if (adv) s11_vld_r <= s10_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s11_flt_r <= s10_flt_r;
      s11_t_r   <= s10_t_r;
      s11_pa_r  <= s10_pa_r;
      s11_x1e_r <= bpc_pkg::asr(32'(s10_x1d_r * bpc_pkg::K_X1), 5'd16);
      s11_x2e_r <= s10_x2e_r;
    end
  end

  // Output register.
  bpc_pkg::out_req_t out_r;
  logic [31:0] pb_w;
  assign pb_w = s11_pa_r + bpc_pkg::asr(s11_x1e_r + s11_x2e_r + bpc_pkg::K_ADD, 5'd4);
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= s11_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.div_fault   <= s11_flt_r;
      out_r.temp_deci   <= s11_flt_r ? '0 : s11_t_r;
      out_r.pressure_pa <= s11_flt_r ? '0 : pb_w;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.div_fault |-> out_ch.data.pressure_pa == '0)
    else $error("fault result not zero");
  a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while pipeline frozen");
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted request lost at stage one");

endmodule
`default_nettype wire

// File: sv/bpc_div.sv
// Pipelined restoring divider: one quotient bit per stage, 32 stages.
`timescale 1ns / 1ps
`default_nettype none
module bpc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        in_vld,
  input  wire logic [31:0] in_num,
  input  wire logic [31:0] in_den,
  output logic             out_vld,
  output logic [31:0]      out_quo
);

  localparam int unsigned N = bpc_pkg::QW;

  logic [N-1:0]  vld_r;
  logic [31:0]   num_r [N];
  logic [31:0]   den_r [N];
  logic [32:0]   rem_r [N];
  logic [31:0]   quo_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < N; i++) begin
        logic [32:0] rs;
        logic [31:0] nm;
        logic [31:0] dn;
        logic [32:0] rp;
        logic [31:0] qp;
        if (i == 0) begin
          rp = '0;
          qp = '0;
          nm = in_num;
          dn = in_den;
        end else begin
          rp = rem_r[i-1];
          qp = quo_r[i-1];
          nm = num_r[i-1];
          dn = den_r[i-1];
        end
        rs = {rp[31:0], nm[N-1-i]};
        if (rs >= {1'b0, dn}) begin
          rem_r[i] <= rs - {1'b0, dn};
          quo_r[i] <= {qp[30:0], 1'b1};
        end else begin
          rem_r[i] <= rs;
          quo_r[i] <= {qp[30:0], 1'b0};
        end
        num_r[i] <= nm;
        den_r[i] <= dn;
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign out_quo = quo_r[N-1];

endmodule
`default_nettype wire

// File: sv/bpc_delay.sv
// Delay line: holds a payload word for the latency of one divider.
`timescale 1ns / 1ps
`default_nettype none
module bpc_delay (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [95:0] d,
  output logic [95:0]      q
);

  logic [95:0] line_r [bpc_pkg::QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      line_r[0] <= d;
      for (int i = 1; i < bpc_pkg::QW; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign q = line_r[bpc_pkg::QW-1];

endmodule
`default_nettype wire
